// ===== rtl/core/pmtp_pkg.sv =====
// Package for the PMT section parser: result word types, kind codes,
// header and entry byte positions, descriptor tags and stream types.
// No dependencies.
`default_nettype none

package pmtp_pkg;

    localparam int MAX_SECTION_BYTES_DEF = 1024;

    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = 2;
    localparam int Q_CW    = 3;

    localparam logic [2:0] KIND_HEADER      = 3'd0;
    localparam logic [2:0] KIND_VIDEO       = 3'd1;
    localparam logic [2:0] KIND_MPEG_AUDIO  = 3'd2;
    localparam logic [2:0] KIND_AC3_AUDIO   = 3'd3;
    localparam logic [2:0] KIND_TELETEXT    = 3'd4;
    localparam logic [2:0] KIND_SECTION_END = 3'd5;

    localparam int HDR_BYTES = 12;

    localparam logic [3:0] POS_LEN_HI  = 4'd1;
    localparam logic [3:0] POS_LEN_LO  = 4'd2;
    localparam logic [3:0] POS_PROG_HI = 4'd3;
    localparam logic [3:0] POS_PROG_LO = 4'd4;
    localparam logic [3:0] POS_VERSION = 4'd5;
    localparam logic [3:0] POS_PCR_HI  = 4'd8;
    localparam logic [3:0] POS_PCR_LO  = 4'd9;
    localparam logic [3:0] POS_PIL_HI  = 4'd10;
    localparam logic [3:0] POS_PIL_LO  = 4'd11;

    localparam logic [11:0] ES_TYPE   = 12'd0;
    localparam logic [11:0] ES_PID_HI = 12'd1;
    localparam logic [11:0] ES_PID_LO = 12'd2;
    localparam logic [11:0] ES_LEN_HI = 12'd3;
    localparam logic [11:0] ES_LEN_LO = 12'd4;
    localparam logic [11:0] ES_FIXED  = 12'd5;

    localparam logic [1:0] DS_TAG  = 2'd0;
    localparam logic [1:0] DS_LEN  = 2'd1;
    localparam logic [1:0] DS_BODY = 2'd2;

    localparam logic [7:0] TAG_LANGUAGE  = 8'h0A;
    localparam logic [7:0] TAG_STREAM_ID = 8'h52;
    localparam logic [7:0] TAG_TELETEXT  = 8'h56;
    localparam logic [7:0] TAG_AC3       = 8'h6A;
    localparam logic [7:0] TAG_NONE      = 8'hFF;

    localparam logic [7:0] STYPE_MPEG1_VIDEO = 8'h01;
    localparam logic [7:0] STYPE_MPEG2_VIDEO = 8'h02;
    localparam logic [7:0] STYPE_MPEG1_AUDIO = 8'h03;
    localparam logic [7:0] STYPE_MPEG2_AUDIO = 8'h04;
    localparam logic [7:0] STYPE_PRIVATE_PES = 8'h06;

    localparam int FLB_AC3  = 0;
    localparam int FLB_TTX  = 1;
    localparam int FLB_LANG = 2;

    typedef struct packed {
        logic [2:0]  kind;
        logic [12:0] pid;
        logic [15:0] service_id;
        logic [4:0]  version;
        logic        current_next;
        logic [23:0] language;
        logic        language_valid;
        logic [7:0]  component_tag;
        logic        last;
    } t_result;

    typedef struct packed {
        logic    v0;
        logic    v1;
        t_result r0;
        t_result r1;
    } t_push;

    typedef struct packed {
        logic [11:0] offset;
        logic [11:0] info_len;
        logic [7:0]  etype;
        logic [12:0] pid;
        logic [7:0]  dtag;
        logic [7:0]  drem;
        logic [7:0]  dlen;
        logic [1:0]  dstep;
        logic [23:0] lang;
        logic [2:0]  flags;
        logic [7:0]  tag;
    } t_entry;

    function automatic t_entry entry_clear();
        t_entry e;
        e       = '0;
        e.dstep = DS_TAG;
        e.tag   = TAG_NONE;
        return e;
    endfunction

    function automatic t_result mk_result(
        input logic [2:0]  kind,
        input logic [12:0] pid,
        input logic [15:0] prog,
        input logic [5:0]  ver,
        input logic [23:0] lang,
        input logic        lang_valid,
        input logic [7:0]  tag
    );
        t_result r;
        r.kind           = kind;
        r.pid            = pid;
        r.service_id     = prog;
        r.version        = ver[5:1];
        r.current_next   = ver[0];
        r.language       = lang;
        r.language_valid = lang_valid;
        r.component_tag  = tag;
        r.last           = 1'b0;
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/pmtp_parser.sv =====
// Byte parser of the PMT section: header fields, entry walk and descriptors.
// Produces up to two result words per byte. Depends on pmtp_pkg.
`default_nettype none

module pmtp_parser #(
    parameter int MAX_SECTION_BYTES = pmtp_pkg::MAX_SECTION_BYTES_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_en,
    input  wire logic [7:0]     i_data_byte,
    input  wire logic           i_section_start,
    output pmtp_pkg::t_push     o_push
);

    localparam int POS_W = $clog2(MAX_SECTION_BYTES);

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_BUSY = 2'd1;
    localparam logic [1:0] PH_DONE = 2'd2;

    logic [1:0]       r_phase, n_phase;
    logic [POS_W-1:0] r_byte_pos, n_byte_pos;
    logic [11:0]      r_section_len, n_section_len;
    logic [11:0]      r_prog_info_len, n_prog_info_len;
    logic [15:0]      r_hdr_program, n_hdr_program;
    logic [5:0]       r_hdr_version, n_hdr_version;
    pmtp_pkg::t_entry r_ent, n_ent;
    pmtp_pkg::t_push  n_push;
    logic [12:0]      w_p13;
    logic [7:0]       w_idx;
    logic             w_emit;

    always_comb begin
        n_phase         = r_phase;
        n_byte_pos      = r_byte_pos;
        n_section_len   = r_section_len;
        n_prog_info_len = r_prog_info_len;
        n_hdr_program   = r_hdr_program;
        n_hdr_version   = r_hdr_version;
        n_ent           = r_ent;
        n_push          = '0;
        w_idx           = '0;
        w_emit          = 1'b0;

        if (i_section_start) begin
            n_phase         = PH_BUSY;
            n_byte_pos      = '0;
            n_section_len   = '0;
            n_prog_info_len = '0;
            n_hdr_program   = '0;
            n_hdr_version   = '0;
            n_ent           = pmtp_pkg::entry_clear();
        end
        w_p13 = 13'(n_byte_pos);

        if (n_phase == PH_BUSY) begin
            if (w_p13 < 13'(pmtp_pkg::HDR_BYTES)) begin
                case (w_p13[3:0])
                    pmtp_pkg::POS_LEN_HI: begin
                        n_section_len = {i_data_byte[3:0], 8'h00};
                    end
                    pmtp_pkg::POS_LEN_LO: begin
                        n_section_len = n_section_len | {4'h0, i_data_byte};
                    end
                    pmtp_pkg::POS_PROG_HI: begin
                        n_hdr_program = {i_data_byte, 8'h00};
                    end
                    pmtp_pkg::POS_PROG_LO: begin
                        n_hdr_program = n_hdr_program | {8'h00, i_data_byte};
                    end
                    pmtp_pkg::POS_VERSION: begin
                        n_hdr_version = i_data_byte[5:0];
                    end
                    pmtp_pkg::POS_PCR_HI: begin
                        n_ent.pid = {i_data_byte[4:0], 8'h00};
                    end
                    pmtp_pkg::POS_PCR_LO: begin
                        n_push.v0 = 1'b1;
                        n_push.r0 = pmtp_pkg::mk_result(pmtp_pkg::KIND_HEADER,
                            n_ent.pid | {5'h00, i_data_byte}, n_hdr_program,
                            n_hdr_version, 24'h0, 1'b0, pmtp_pkg::TAG_NONE);
                        n_ent.pid = '0;
                    end
                    pmtp_pkg::POS_PIL_HI: begin
                        n_prog_info_len = {i_data_byte[3:0], 8'h00};
                    end
                    pmtp_pkg::POS_PIL_LO: begin
                        n_prog_info_len = n_prog_info_len | {4'h0, i_data_byte};
                    end
                    default: begin
                    end
                endcase
            end else if ((w_p13 + 13'd1 >= {1'b0, n_section_len}) ||
                         (w_p13 + 13'd1 >= 13'(MAX_SECTION_BYTES))) begin
                n_push.v0 = 1'b1;
                n_push.r0 = pmtp_pkg::mk_result(pmtp_pkg::KIND_SECTION_END, 13'h0,
                    n_hdr_program, n_hdr_version, 24'h0, 1'b0, pmtp_pkg::TAG_NONE);
                n_phase   = PH_DONE;
            end else if (w_p13 >= 13'(pmtp_pkg::HDR_BYTES) + {1'b0, n_prog_info_len}) begin
                case (n_ent.offset)
                    pmtp_pkg::ES_TYPE: begin
                        n_ent       = pmtp_pkg::entry_clear();
                        n_ent.etype = i_data_byte;
                    end
                    pmtp_pkg::ES_PID_HI: begin
                        n_ent.pid = {i_data_byte[4:0], 8'h00};
                    end
                    pmtp_pkg::ES_PID_LO: begin
                        n_ent.pid = n_ent.pid | {5'h00, i_data_byte};
                    end
                    pmtp_pkg::ES_LEN_HI: begin
                        n_ent.info_len = {i_data_byte[3:0], 8'h00};
                    end
                    pmtp_pkg::ES_LEN_LO: begin
                        n_ent.info_len = n_ent.info_len | {4'h0, i_data_byte};
                        n_ent.dstep    = pmtp_pkg::DS_TAG;
                    end
                    default: begin
                        case (n_ent.dstep)
                            pmtp_pkg::DS_TAG: begin
                                n_ent.dtag = i_data_byte;
                                if (i_data_byte == pmtp_pkg::TAG_TELETEXT) begin
                                    n_ent.flags[pmtp_pkg::FLB_TTX] = 1'b1;
                                end
                                if (i_data_byte == pmtp_pkg::TAG_AC3) begin
                                    n_ent.flags[pmtp_pkg::FLB_AC3] = 1'b1;
                                end
                                if (i_data_byte == pmtp_pkg::TAG_LANGUAGE) begin
                                    n_ent.flags[pmtp_pkg::FLB_LANG] = 1'b1;
                                    n_ent.lang                      = '0;
                                end
                                n_ent.dstep = pmtp_pkg::DS_LEN;
                            end
                            pmtp_pkg::DS_LEN: begin
                                n_ent.dlen  = i_data_byte;
                                n_ent.drem  = i_data_byte;
                                n_ent.dstep = (i_data_byte != 8'h00) ?
                                              pmtp_pkg::DS_BODY : pmtp_pkg::DS_TAG;
                            end
                            default: begin
                                w_idx = n_ent.dlen - n_ent.drem;
                                if (n_ent.dtag == pmtp_pkg::TAG_LANGUAGE) begin
                                    case (w_idx)
                                        8'd0: n_ent.lang[23:16] = i_data_byte;
                                        8'd1: n_ent.lang[15:8]  = i_data_byte;
                                        8'd2: n_ent.lang[7:0]   = i_data_byte;
                                        default: begin
                                        end
                                    endcase
                                end
                                if (n_ent.dtag == pmtp_pkg::TAG_STREAM_ID &&
                                    w_idx == 8'd0) begin
                                    n_ent.tag = i_data_byte;
                                end
                                n_ent.drem = n_ent.drem - 8'd1;
                                if (n_ent.drem == 8'd0) begin
                                    n_ent.dstep = pmtp_pkg::DS_TAG;
                                end
                            end
                        endcase
                    end
                endcase
                n_ent.offset = n_ent.offset + 12'd1;
                w_emit = (n_ent.offset >= pmtp_pkg::ES_FIXED) &&
                         ({1'b0, n_ent.offset} ==
                          {1'b0, pmtp_pkg::ES_FIXED} + {1'b0, n_ent.info_len});
                if (w_emit) begin
                    if (n_ent.etype == pmtp_pkg::STYPE_MPEG1_VIDEO ||
                        n_ent.etype == pmtp_pkg::STYPE_MPEG2_VIDEO) begin
                        n_push.v0 = 1'b1;
                        n_push.r0 = pmtp_pkg::mk_result(pmtp_pkg::KIND_VIDEO, n_ent.pid,
                            n_hdr_program, n_hdr_version, 24'h0, 1'b0,
                            pmtp_pkg::TAG_NONE);
                    end else if (n_ent.etype == pmtp_pkg::STYPE_MPEG1_AUDIO ||
                                 n_ent.etype == pmtp_pkg::STYPE_MPEG2_AUDIO) begin
                        n_push.v0 = 1'b1;
                        n_push.r0 = pmtp_pkg::mk_result(pmtp_pkg::KIND_MPEG_AUDIO,
                            n_ent.pid, n_hdr_program, n_hdr_version, n_ent.lang,
                            n_ent.flags[pmtp_pkg::FLB_LANG], n_ent.tag);
                    end else if (n_ent.etype == pmtp_pkg::STYPE_PRIVATE_PES &&
                                 n_ent.flags[pmtp_pkg::FLB_AC3]) begin
                        n_push.v0 = 1'b1;
                        n_push.r0 = pmtp_pkg::mk_result(pmtp_pkg::KIND_AC3_AUDIO,
                            n_ent.pid, n_hdr_program, n_hdr_version, n_ent.lang,
                            n_ent.flags[pmtp_pkg::FLB_LANG], n_ent.tag);
                    end
                    if (n_ent.flags[pmtp_pkg::FLB_TTX]) begin
                        if (n_push.v0) begin
                            n_push.v1 = 1'b1;
                            n_push.r1 = pmtp_pkg::mk_result(pmtp_pkg::KIND_TELETEXT,
                                n_ent.pid, n_hdr_program, n_hdr_version, 24'h0, 1'b0,
                                pmtp_pkg::TAG_NONE);
                        end else begin
                            n_push.v0 = 1'b1;
                            n_push.r0 = pmtp_pkg::mk_result(pmtp_pkg::KIND_TELETEXT,
                                n_ent.pid, n_hdr_program, n_hdr_version, 24'h0, 1'b0,
                                pmtp_pkg::TAG_NONE);
                        end
                    end
                    n_ent = pmtp_pkg::entry_clear();
                end
            end
            if (n_phase == PH_BUSY) begin
                n_byte_pos = n_byte_pos + POS_W'(1);
            end
        end

        if (n_push.v1) begin
            n_push.r1.last = 1'b1;
        end else if (n_push.v0) begin
            n_push.r0.last = 1'b1;
        end
    end

    always_comb begin
        o_push = n_push;
        if (!i_en) begin
            o_push.v0 = 1'b0;
            o_push.v1 = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase         <= PH_IDLE;
            r_byte_pos      <= '0;
            r_section_len   <= '0;
            r_prog_info_len <= '0;
            r_hdr_program   <= '0;
            r_hdr_version   <= '0;
            r_ent           <= pmtp_pkg::entry_clear();
        end else if (i_en) begin
            r_phase         <= n_phase;
            r_byte_pos      <= n_byte_pos;
            r_section_len   <= n_section_len;
            r_prog_info_len <= n_prog_info_len;
            r_hdr_program   <= n_hdr_program;
            r_hdr_version   <= n_hdr_version;
            r_ent           <= n_ent;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/pmtp_queue.sv =====
// Result queue of the PMT section parser: takes up to two result words a
// cycle and hands out one word a cycle while i_stall is low. Depends on pmtp_pkg.
`default_nettype none

module pmtp_queue (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire pmtp_pkg::t_push  i_push,
    output logic                  o_ready,
    output logic                  o_valid,
    input  wire logic             i_stall,
    output pmtp_pkg::t_result     o_res
);

    pmtp_pkg::t_result             r_mem [pmtp_pkg::Q_DEPTH];
    logic [pmtp_pkg::Q_AW-1:0]     r_wr, n_wr;
    logic [pmtp_pkg::Q_AW-1:0]     r_rd, n_rd;
    logic [pmtp_pkg::Q_CW-1:0]     r_count, n_count;
    logic [pmtp_pkg::Q_CW-1:0]     w_nput;
    logic                          w_pop;

    assign o_valid = (r_count != '0);
    assign o_res   = r_mem[r_rd];
    assign o_ready = (r_count <= pmtp_pkg::Q_CW'(pmtp_pkg::Q_DEPTH - 2));
    assign w_pop   = o_valid && !i_stall;
    assign w_nput  = pmtp_pkg::Q_CW'(i_push.v0) + pmtp_pkg::Q_CW'(i_push.v1);

    always_comb begin
        n_wr    = r_wr + pmtp_pkg::Q_AW'(w_nput);
        n_rd    = r_rd + pmtp_pkg::Q_AW'(w_pop);
        n_count = r_count + w_nput - pmtp_pkg::Q_CW'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.v0) begin
            r_mem[r_wr] <= i_push.r0;
        end
        if (i_push.v1) begin
            r_mem[r_wr + pmtp_pkg::Q_AW'(1)] <= i_push.r1;
        end
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= pmtp_pkg::Q_CW'(pmtp_pkg::Q_DEPTH))
        else $error("result queue holds more words than its depth");

    a_second_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.v1 |-> i_push.v0)
        else $error("second result word pushed without the first");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push.v0 || i_push.v1) |-> o_ready)
        else $error("result pushed while the queue lacks room for two words");

    a_pop_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pop && !i_push.v0) |=> (r_count == $past(r_count) - pmtp_pkg::Q_CW'(1)))
        else $error("queue count did not fall after a lone pop");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/pmt_section_parser.sv =====
// Top level of the PMT section parser: input register, byte parser and
// result queue. Depends on pmtp_pkg, pmtp_parser and pmtp_queue.
//
// Usage: section bytes enter one word per cycle on i_valid/o_stall with
// i_section_start high on the table_id byte. Results leave on o_valid/
// i_stall, one word per cycle, with o_last on the final word of a byte.
// A header word follows byte 9, stream words follow the last byte of each
// elementary stream entry, and a section-end word follows the first CRC
// byte; later bytes are dropped until the next start.
// Path: an accepted byte is held in the input register, parsed
// combinationally, and its result words are written into the queue.
// Throughput: one byte per cycle while o_stall is low; set by the single
// parse stage. The two words of a byte (stream and teletext) are held in
// a four-word queue; o_stall rises while the input register waits for
// room for two words, so a stalled receiver backs up to the sender.
// Reset clears the parser to idle and empties the queue and input register.
`default_nettype none

module pmt_section_parser #(
    parameter int MAX_SECTION_BYTES = pmtp_pkg::MAX_SECTION_BYTES_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_section_start,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [2:0]       o_kind,
    output logic [12:0]      o_pid,
    output logic [15:0]      o_service_id,
    output logic [4:0]       o_version,
    output logic             o_current_next,
    output logic [23:0]      o_language,
    output logic             o_language_valid,
    output logic [7:0]       o_component_tag,
    output logic             o_last
);

    logic              r_in_valid, n_in_valid;
    logic [7:0]        r_in_byte;
    logic              r_in_start;
    logic              w_ready;
    logic              w_advance;
    logic              w_accept;
    pmtp_pkg::t_push   w_push;
    pmtp_pkg::t_result w_res;

    assign w_advance = r_in_valid && w_ready;
    assign o_stall   = r_in_valid && !w_ready;
    assign w_accept  = i_valid && !o_stall;

    always_comb begin
        n_in_valid = r_in_valid;
        if (w_accept) begin
            n_in_valid = 1'b1;
        end else if (w_advance) begin
            n_in_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_byte  <= i_data_byte;
            r_in_start <= i_section_start;
        end
    end

    pmtp_parser #(
        .MAX_SECTION_BYTES(MAX_SECTION_BYTES)
    ) u_parser (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (w_advance),
        .i_data_byte    (r_in_byte),
        .i_section_start(r_in_start),
        .o_push         (w_push)
    );

    pmtp_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_push),
        .o_ready(w_ready),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_res  (w_res)
    );

    assign o_kind           = w_res.kind;
    assign o_pid            = w_res.pid;
    assign o_service_id     = w_res.service_id;
    assign o_version        = w_res.version;
    assign o_current_next   = w_res.current_next;
    assign o_language       = w_res.language;
    assign o_language_valid = w_res.language_valid;
    assign o_component_tag  = w_res.component_tag;
    assign o_last           = w_res.last;

endmodule

`default_nettype wire
